// ===== rtl/core/md5sp_pkg.sv =====
package md5sp_pkg;

  localparam int WORD_W = 32;
  localparam int MSG_DEPTH = 16;
  localparam int WIN_DEPTH = 4;

  localparam logic [1:0] MODE_LOAD_MSG = 2'd0;
  localparam logic [1:0] MODE_LOAD_WIN = 2'd1;
  localparam logic [1:0] MODE_STEP = 2'd2;

  // per-lane control, one request at a time
  typedef struct packed {
    logic msg_we;
    logic win_we;
    logic step_go;
    logic commit;
  } md5sp_ctrl_t;

  // chaining words, newest slot first
  localparam logic [WORD_W-1:0] WIN_INIT [WIN_DEPTH] = '{
    32'hefcdab89, 32'h98badcfe, 32'h10325476, 32'h67452301
  };

  localparam logic [WORD_W-1:0] STEP_CONST [64] = '{
    32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
    32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
    32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
    32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
    32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
    32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
    32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
    32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
    32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
    32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
    32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
    32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
    32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
    32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
    32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
    32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
  };

  localparam logic [4:0] ROT_AMOUNT [16] = '{
    5'd7, 5'd12, 5'd17, 5'd22,
    5'd5, 5'd9,  5'd14, 5'd20,
    5'd4, 5'd11, 5'd16, 5'd23,
    5'd6, 5'd10, 5'd15, 5'd21
  };

  function automatic logic [3:0] word_for_step(input logic [5:0] step);
    logic [3:0] j;
    logic [3:0] w;
    j = step[3:0];
    case (step[5:4])
      2'd0: w = j;
      2'd1: w = 4'((j << 2) + j + 4'd1);
      2'd2: w = 4'((j << 1) + j + 4'd5);
      default: w = 4'((j << 3) - j);
    endcase
    return w;
  endfunction

  function automatic logic [WORD_W-1:0] round_fn(input logic [1:0] rnd,
                                                 input logic [WORD_W-1:0] x,
                                                 input logic [WORD_W-1:0] y,
                                                 input logic [WORD_W-1:0] z);
    logic [WORD_W-1:0] f;
    case (rnd)
      2'd0: f = z ^ (x & (y ^ z));
      2'd1: f = y ^ (z & (x ^ y));
      2'd2: f = x ^ y ^ z;
      default: f = y ^ (x | ~z);
    endcase
    return f;
  endfunction

endpackage

// ===== rtl/core/md5sp_lane.sv =====
module md5sp_lane (
  input  logic                           clk,
  input  logic                           rst,
  input  md5sp_pkg::md5sp_ctrl_t         ctrl,
  input  logic [3:0]                     word_index,
  input  logic [md5sp_pkg::WORD_W-1:0]   load_value,
  input  logic [5:0]                     step_index,
  output logic [md5sp_pkg::WORD_W-1:0]   new_word
);

  logic [md5sp_pkg::WORD_W-1:0] msg [md5sp_pkg::MSG_DEPTH];
  logic [md5sp_pkg::WORD_W-1:0] win [md5sp_pkg::WIN_DEPTH];
  logic [md5sp_pkg::WORD_W-1:0] sum;
  logic [md5sp_pkg::WORD_W-1:0] sum_next;
  logic [4:0]                   shift;
  logic [2*md5sp_pkg::WORD_W-1:0] rot_wide;

  always_ff @(posedge clk) begin
    if (ctrl.msg_we) begin
      msg[word_index] <= load_value;
    end
  end

  // stage one: function plus oldest word, message word and constant
  always_comb begin
    sum_next = md5sp_pkg::round_fn(step_index[5:4], win[0], win[1], win[2])
             + win[3]
             + msg[md5sp_pkg::word_for_step(step_index)]
             + md5sp_pkg::STEP_CONST[step_index];
  end

  always_ff @(posedge clk) begin
    if (ctrl.step_go) begin
      sum   <= sum_next;
      shift <= md5sp_pkg::ROT_AMOUNT[{step_index[5:4], step_index[1:0]}];
    end
  end

  // stage two: rotate and add newest word
  assign rot_wide = {sum, sum} << shift;
  assign new_word = rot_wide[2*md5sp_pkg::WORD_W-1:md5sp_pkg::WORD_W] + win[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < md5sp_pkg::WIN_DEPTH; i++) begin
        win[i] <= md5sp_pkg::WIN_INIT[i];
      end
    end else if (ctrl.commit) begin
      win[3] <= win[2];
      win[2] <= win[1];
      win[1] <= win[0];
      win[0] <= new_word;
    end else if (ctrl.win_we) begin
      win[word_index[1:0]] <= load_value;
    end
  end

endmodule

// ===== rtl/core/md5sp_merge.sv =====
module md5sp_merge (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           commit,
  input  logic [md5sp_pkg::WORD_W-1:0]   first_word,
  input  logic [md5sp_pkg::WORD_W-1:0]   second_word,
  output logic                           free,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [2*md5sp_pkg::WORD_W-1:0] m_tdata
);

  assign free = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (commit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      m_tdata <= {second_word, first_word};
    end
  end

endmodule

// ===== rtl/core/md5_step_pair.sv =====
// Two MD5 lanes, one per message, run the same step side by side.
// Step request: the sum stage is registered on acceptance, then the rotate/add
// stage feeds the window and output once the output is free; no new request is
// taken while a step is in flight. Load requests give no result and do not stall.
// Synchronous active-high reset: windows return to the chaining words,
// output empties; message stores are not cleared.
module md5_step_pair (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [47:0] s_tdata,  // word_index[3:0], load_value[35:4], step_index[41:36]
  input  logic [2:0]  s_tuser,  // mode[1:0], message_select[2]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [63:0] m_tdata   // first_state_word[31:0], second_state_word[63:32]
);

  logic [1:0]  mode;
  logic        message_select;
  logic [3:0]  word_index;
  logic [31:0] load_value;
  logic [5:0]  step_index;
  logic        accept;
  logic        busy;
  logic        commit;
  logic        free;
  logic [31:0] first_word;
  logic [31:0] second_word;
  md5sp_pkg::md5sp_ctrl_t ctrl_first;
  md5sp_pkg::md5sp_ctrl_t ctrl_second;

  assign mode           = s_tuser[1:0];
  assign message_select = s_tuser[2];
  assign word_index     = s_tdata[3:0];
  assign load_value     = s_tdata[35:4];
  assign step_index     = s_tdata[41:36];

  assign s_tready = !busy;
  assign accept   = s_tvalid && s_tready;
  assign commit   = busy && free;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (accept && mode == md5sp_pkg::MODE_STEP) begin
      busy <= 1'b1;
    end else if (commit) begin
      busy <= 1'b0;
    end
  end

  always_comb begin
    ctrl_first.msg_we  = accept && mode == md5sp_pkg::MODE_LOAD_MSG && !message_select;
    ctrl_first.win_we  = accept && mode == md5sp_pkg::MODE_LOAD_WIN && !message_select
                         && word_index[3:2] == 2'd0;
    ctrl_first.step_go = accept && mode == md5sp_pkg::MODE_STEP;
    ctrl_first.commit  = commit;
    ctrl_second.msg_we = accept && mode == md5sp_pkg::MODE_LOAD_MSG && message_select;
    ctrl_second.win_we = accept && mode == md5sp_pkg::MODE_LOAD_WIN && message_select
                         && word_index[3:2] == 2'd0;
    ctrl_second.step_go = ctrl_first.step_go;
    ctrl_second.commit  = commit;
  end

  md5sp_lane u_lane_first (
    .clk        (clk),
    .rst        (rst),
    .ctrl       (ctrl_first),
    .word_index (word_index),
    .load_value (load_value),
    .step_index (step_index),
    .new_word   (first_word)
  );

  md5sp_lane u_lane_second (
    .clk        (clk),
    .rst        (rst),
    .ctrl       (ctrl_second),
    .word_index (word_index),
    .load_value (load_value),
    .step_index (step_index),
    .new_word   (second_word)
  );

  md5sp_merge u_merge (
    .clk         (clk),
    .rst         (rst),
    .commit      (commit),
    .first_word  (first_word),
    .second_word (second_word),
    .free        (free),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata)
  );

endmodule

// ===== rtl/core/md5sp_checker.sv =====
module md5sp_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic [2:0]  s_tuser,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [63:0] m_tdata
);

  logic step_req;
  logic load_req;

  assign step_req = s_tvalid && s_tready && s_tuser[1:0] == md5sp_pkg::MODE_STEP;
  assign load_req = s_tvalid && s_tready && s_tuser[1:0] != md5sp_pkg::MODE_STEP;

  a_reset_state: assert property (@(posedge clk) rst |=> !m_tvalid && s_tready)
    else $error("not empty after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled result changed");

  a_step_blocks: assert property (@(posedge clk) disable iff (rst)
    step_req |=> !s_tready)
    else $error("request taken during step");

  a_load_free: assert property (@(posedge clk) disable iff (rst)
    load_req |=> s_tready)
    else $error("load stalled input");

  a_step_result: assert property (@(posedge clk) disable iff (rst)
    step_req && !m_tvalid |=> ##1 m_tvalid)
    else $error("step result missing");

endmodule

bind md5_step_pair md5sp_checker u_md5sp_checker (.*);
